FILE: design/ppls_pkg.sv
// Shared types and constants of the periodic priority list scheduler.
// No dependencies; used by every module of the block.
package ppls_pkg;

   localparam int NUM_SLOTS  = 4;
   localparam int LIST_W     = 2;
   localparam int POS_W      = 8;
   localparam int CNT_W      = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_MANUAL = 2'd1;
   localparam logic [1:0] REQ_FETCH  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_BASE = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH_BASE = 4'd4;

   localparam logic [CNT_W-1:0] PERIOD_RESET = 16'hFFFF;
   localparam logic [POS_W-1:0] LENGTH_RESET = 8'd0;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_MANUAL = 2'd1,
      OP_FETCH  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [LIST_W-1:0] list_num;
   } cmd_type;

   typedef struct packed {
      logic              triggered;
      logic              item_valid;
      logic [LIST_W-1:0] item_list;
      logic [POS_W-1:0]  item_position;
   } rsp_type;

endpackage

FILE: design/ppls_front.sv
// Front end: accepts request transactions and decodes them into commands.
// Depends on ppls_pkg.
module ppls_front #(
   parameter int NUM_LISTS = 4
) (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_type,
   input  logic [ppls_pkg::LIST_W-1:0] list_number,
   input  logic                        queue_full,
   output logic                        push,
   output ppls_pkg::cmd_type           push_cmd
);
   import ppls_pkg::*;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_cmd.list_num = list_number;
      case (req_type)
         REQ_TICK:   push_cmd.op = OP_TICK;
         REQ_MANUAL: begin
            // out-of-range list numbers become a no-op command here
            if ({1'b0, list_number} < (LIST_W + 1)'(NUM_LISTS))
               push_cmd.op = OP_MANUAL;
            else
               push_cmd.op = OP_NONE;
         end
         REQ_FETCH:  push_cmd.op = OP_FETCH;
         default:    push_cmd.op = OP_NONE;
      endcase
   end

endmodule

FILE: design/ppls_queue.sv
// Two-entry command queue between front and back end.
// Depends on ppls_pkg.
module ppls_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ppls_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output ppls_pkg::cmd_type pop_cmd
);
   import ppls_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/ppls_back.sv
// Back end: list state, configuration registers, command execution and
// the registered response stage. Depends on ppls_pkg.
module ppls_back #(
   parameter int NUM_LISTS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ppls_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ppls_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            cmd_valid,
   input  ppls_pkg::cmd_type               cmd,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output ppls_pkg::rsp_type               rsp
);
   import ppls_pkg::*;

   logic [CNT_W-1:0]     period_ff [NUM_LISTS];
   logic [POS_W-1:0]     length_ff [NUM_LISTS];
   logic [NUM_LISTS-1:0] flag_ff, flag_in;
   logic [CNT_W-1:0]     cnt_ff [NUM_LISTS];
   logic [CNT_W-1:0]     cnt_in [NUM_LISTS];
   logic [POS_W-1:0]     pos_ff [NUM_LISTS];
   logic [POS_W-1:0]     pos_in [NUM_LISTS];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   assign pop        = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      logic found;
      found   = 1'b0;
      flag_in = flag_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      rsp_in  = '0;
      if (pop) begin
         case (cmd.op)
            OP_TICK: begin
               for (int i = 0; i < NUM_LISTS; i++) begin
                  if (cnt_ff[i] >= period_ff[i]) begin
                     cnt_in[i]        = '0;
                     flag_in[i]       = 1'b1;
                     rsp_in.triggered = 1'b1;
                  end else begin
                     cnt_in[i] = cnt_ff[i] + 1'b1;
                  end
               end
            end
            OP_MANUAL: begin
               for (int i = 0; i < NUM_LISTS; i++) begin
                  if (cmd.list_num == LIST_W'(i)) begin
                     flag_in[i] = 1'b1;
                     cnt_in[i]  = '0;
                  end
               end
            end
            OP_FETCH: begin
               // finished lists ahead of the winner are retired
               for (int i = 0; i < NUM_LISTS; i++) begin
                  if (!found && flag_ff[i]) begin
                     if (pos_ff[i] >= length_ff[i]) begin
                        flag_in[i] = 1'b0;
                        pos_in[i]  = '0;
                     end else begin
                        found                = 1'b1;
                        rsp_in.item_valid    = 1'b1;
                        rsp_in.item_list     = LIST_W'(i);
                        rsp_in.item_position = pos_ff[i];
                        pos_in[i]            = pos_ff[i] + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pop)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop)
         rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         flag_ff      <= '0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            cnt_ff[i]    <= '0;
            pos_ff[i]    <= '0;
            period_ff[i] <= PERIOD_RESET;
            length_ff[i] <= LENGTH_RESET;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
         for (int i = 0; i < NUM_LISTS; i++) begin
            cnt_ff[i] <= cnt_in[i];
            pos_ff[i] <= pos_in[i];
            if (csr_we && csr_addr == CSR_PERIOD_BASE + CSR_ADDR_W'(i))
               period_ff[i] <= csr_wdata;
            if (csr_we && csr_addr == CSR_LENGTH_BASE + CSR_ADDR_W'(i))
               length_ff[i] <= csr_wdata[POS_W-1:0];
         end
      end
   end

endmodule

FILE: design/periodic_priority_list_scheduler.sv
// Periodic priority list scheduler, top level.
// Throughput: one transaction per cycle while responses are taken; the back end
// executes one command per cycle against the four-entry list state, and a 2-entry
// queue buffers stalls.
// Reset (synchronous, active high) clears flags, counters and positions,
// sets periods to 65535 and lengths to 0. Depends on ppls_pkg and submodules.
module periodic_priority_list_scheduler #(
   parameter int NUM_LISTS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ppls_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ppls_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [1:0] list_number
   input  logic [1:0]                      req_tuser,  // [1:0] req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] triggered, [2:1] item_list, [10:3] item_position
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tuser   // [0] item_valid
);
   import ppls_pkg::*;

   logic    push, queue_full, pop, cmd_valid;
   cmd_type push_cmd, cmd;
   rsp_type rsp;

   ppls_front #(.NUM_LISTS(NUM_LISTS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .list_number(req_tdata[LIST_W-1:0]),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ppls_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_valid(cmd_valid),
      .pop_cmd  (cmd)
   );

   ppls_back #(.NUM_LISTS(NUM_LISTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {5'b0, rsp.item_position, rsp.item_list, rsp.triggered};
   assign rsp_tuser = rsp.item_valid;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for periodic_priority_list_scheduler: a queued stream driver,
// a checking monitor and an in-bench scheduler predictor. Depends on ppls_pkg and the RTL.
module tb;
   import ppls_pkg::*;

   localparam int NUM_LISTS = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_FIRST = CSR_LENGTH_BASE + 4'(NUM_SLOTS);
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;   // [1:0] list_number
   logic [1:0] req_tuser = '0;   // [1:0] req_type
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // [0] triggered, [2:1] item_list, [10:3] item_position
   logic rsp_tuser;              // [0] item_valid

   periodic_priority_list_scheduler #(.NUM_LISTS(NUM_LISTS)) dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scheduler state mirror
   logic [CNT_W-1:0] period_cfg [NUM_SLOTS];
   logic [POS_W-1:0] length_cfg [NUM_SLOTS];
   logic             list_req   [NUM_SLOTS];
   logic [CNT_W-1:0] tick_cnt   [NUM_SLOTS];
   logic [POS_W-1:0] list_pos   [NUM_SLOTS];

   cmd_type cmd_queue [$];
   rsp_type expected_rsp [$];

   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   bit  gapless = 1'b0;
   int  sent_cnt = 0;
   int  rsp_cnt = 0;
   int  fire_cnt = 0;
   int  handout_cnt = 0;
   int  mismatch_cnt = 0;

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         period_cfg[i] = PERIOD_RESET;
         length_cfg[i] = LENGTH_RESET;
         list_req[i] = 1'b0;
         tick_cnt[i] = '0;
         list_pos[i] = '0;
      end
   end

   function automatic rsp_type predict_scheduler(op_type op, logic [LIST_W-1:0] lst);
      rsp_type r;
      logic [CNT_W-1:0] prev;
      logic found;
      r = '0;
      found = 1'b0;
      case (op)
         OP_TICK: begin
            for (int i = 0; i < NUM_LISTS; i++) begin
               prev = tick_cnt[i];
               tick_cnt[i] = prev + 1'b1;
               if (prev >= period_cfg[i]) begin
                  tick_cnt[i] = '0;
                  list_req[i] = 1'b1;
                  r.triggered = 1'b1;
               end
            end
         end
         OP_MANUAL: begin
            if (lst < NUM_LISTS) begin
               list_req[lst] = 1'b1;
               tick_cnt[lst] = '0;
            end
         end
         OP_FETCH: begin
            for (int i = 0; i < NUM_LISTS; i++) begin
               if (!found && list_req[i]) begin
                  if (list_pos[i] >= length_cfg[i]) begin
                     list_req[i] = 1'b0;
                     list_pos[i] = '0;
                  end else begin
                     r.item_valid = 1'b1;
                     r.item_list = i[LIST_W-1:0];
                     r.item_position = list_pos[i];
                     list_pos[i] = list_pos[i] + 1'b1;
                     found = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic log_fault(string what, rsp_type want, rsp_type got, logic [15:0] raw);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display({"%0t %s: expected trig=%0b valid=%0b list=%0d pos=%0d, ",
                   "got trig=%0b valid=%0b list=%0d pos=%0d tdata=%h"},
                  $realtime, what, want.triggered, want.item_valid, want.item_list,
                  want.item_position, got.triggered, got.item_valid, got.item_list,
                  got.item_position, raw);
   endtask

   always @(posedge clock) begin : drive_req
      logic next_valid;
      cmd_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_scheduler(op_type'(req_tuser), req_tdata[1:0]));
            sent_cnt++;
            next_valid = 1'b0;
            req_gap = gapless ? 0 : $urandom_range(0, 3);
         end
         if (!next_valid) begin
            if (req_gap > 0)
               req_gap--;
            else if (cmd_queue.size() > 0) begin
               cmd = cmd_queue.pop_front();
               req_tuser <= cmd.op;
               req_tdata <= {6'd0, cmd.list_num};
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   always @(posedge clock) begin : watch_rsp
      logic next_ready;
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         next_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.triggered = rsp_tdata[0];
            got.item_list = rsp_tdata[2:1];
            got.item_position = rsp_tdata[10:3];
            got.item_valid = rsp_tuser;
            rsp_cnt++;
            if (got.triggered === 1'b1) fire_cnt++;
            if (got.item_valid === 1'b1) handout_cnt++;
            if (expected_rsp.size() == 0)
               log_fault("unexpected transaction", '0, got, rsp_tdata);
            else begin
               want = expected_rsp.pop_front();
               if (got !== want || rsp_tdata[15:11] !== 5'd0)
                  log_fault("mismatch", want, got, rsp_tdata);
            end
            next_ready = 1'b0;
            rsp_gap = gapless ? 0 : $urandom_range(0, 3);
            if (rsp_cnt == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (!next_ready) begin
            if (hold_left > 0)
               hold_left--;
            else if (rsp_gap > 0)
               rsp_gap--;
            else
               next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   task automatic queue_cmd(op_type op, logic [LIST_W-1:0] lst);
      cmd_type c;
      c.op = op;
      c.list_num = lst;
      cmd_queue.push_back(c);
   endtask

   task automatic wait_idle();
      while (cmd_queue.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < CSR_LENGTH_BASE)
         period_cfg[idx] = val;
      else if (idx < CSR_UNUSED_FIRST)
         length_cfg[idx - CSR_LENGTH_BASE] = val[POS_W-1:0];
   endtask

   task automatic random_config();
      int pick;
      logic [CSR_DATA_W-1:0] val;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: val = '0;
            1: val = PERIOD_RESET;
            2: val = 16'($urandom);
            default: val = 16'($urandom_range(1, 12));
         endcase
         write_csr(CSR_PERIOD_BASE + i[3:0], val);
      end
      // skipped lengths keep old positions, sometimes past the new end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: val = 16'h00FF;
               1: val = '0;
               2: val = 16'($urandom);
               default: val = 16'($urandom_range(1, 6));
            endcase
            write_csr(CSR_LENGTH_BASE + i[3:0], val);
         end
      end
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_UNUSED_FIRST + 4'($urandom_range(0, 7)), 16'($urandom));
   endtask

   task automatic load_random_items(int count);
      int made;
      int burst;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 1))
               queue_cmd(OP_TICK, 2'($urandom_range(0, 3)));
            else
               queue_cmd(OP_MANUAL, 2'($urandom_range(0, 3)));
            burst = $urandom_range(1, 10);
            repeat (burst) queue_cmd(OP_FETCH, 2'($urandom_range(0, 3)));
            made += burst + 1;
         end else begin
            queue_cmd(op_type'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            made++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // default registers: nothing fires, empty lists retire at once
      queue_cmd(OP_FETCH, 2'd0);
      queue_cmd(OP_TICK, 2'd1);
      queue_cmd(OP_NONE, 2'd2);
      queue_cmd(OP_MANUAL, 2'd0);
      queue_cmd(OP_FETCH, 2'd3);
      wait_idle();

      write_csr(CSR_PERIOD_BASE + 4'd0, '0);
      write_csr(CSR_PERIOD_BASE + 4'd1, 16'd2);
      write_csr(CSR_PERIOD_BASE + 4'd2, PERIOD_RESET);
      write_csr(CSR_PERIOD_BASE + 4'd3, 16'd1);
      write_csr(CSR_LENGTH_BASE + 4'd0, 16'hFF02);
      write_csr(CSR_LENGTH_BASE + 4'd1, 16'd1);
      write_csr(CSR_LENGTH_BASE + 4'd2, 16'h00FF);
      write_csr(CSR_LENGTH_BASE + 4'd3, 16'd3);
      write_csr(CSR_UNUSED_FIRST + 4'd1, 16'h1234);
      write_csr(CSR_UNUSED_FIRST + 4'd7, 16'hFFFF);

      queue_cmd(OP_TICK, 2'd3);
      queue_cmd(OP_FETCH, 2'd0);
      queue_cmd(OP_FETCH, 2'd1);
      queue_cmd(OP_FETCH, 2'd2);
      queue_cmd(OP_MANUAL, 2'd2);
      queue_cmd(OP_MANUAL, 2'd3);
      queue_cmd(OP_FETCH, 2'd3);
      queue_cmd(OP_FETCH, 2'd0);
      queue_cmd(OP_TICK, 2'd0);
      queue_cmd(OP_TICK, 2'd2);
      queue_cmd(OP_TICK, 2'd1);
      queue_cmd(OP_FETCH, 2'd0);
      queue_cmd(OP_FETCH, 2'd1);
      queue_cmd(OP_FETCH, 2'd2);
      queue_cmd(OP_FETCH, 2'd3);
      queue_cmd(OP_NONE, 2'd3);
      wait_idle();

      // shrink list 2 under its current position
      write_csr(CSR_LENGTH_BASE + 4'd2, '0);
      queue_cmd(OP_FETCH, 2'd2);
      queue_cmd(OP_FETCH, 2'd1);
      queue_cmd(OP_FETCH, 2'd0);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         random_config();
         gapless = (phase == 3);
         load_random_items(245);
         wait_idle();
      end

      // full-range periods: counters climb without firing
      gapless = 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++)
         write_csr(CSR_PERIOD_BASE + i[3:0], PERIOD_RESET);
      for (int i = 0; i < NUM_LISTS; i++)
         queue_cmd(OP_MANUAL, i[LIST_W-1:0]);
      repeat (16) queue_cmd(OP_TICK, 2'($urandom_range(0, 3)));
      repeat (4) queue_cmd(OP_FETCH, 2'd0);
      wait_idle();

      repeat (20) @(posedge clock);
      $display("Sent %0d transactions, checked %0d responses.", sent_cnt, rsp_cnt);
      $display("Period fires seen: %0d, list items handed out: %0d, errors: %0d.",
               fire_cnt, handout_cnt, mismatch_cnt);
      if (mismatch_cnt == 0)
         $display("PASS periodic_priority_list_scheduler");
      else
         $display("FAIL periodic_priority_list_scheduler");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL periodic_priority_list_scheduler");
      $finish;
   end

endmodule
